@@ rtl/lfu_pkg.sv @@
// Package for the LFU cache with expiry: sequencer states, register
// indexes, command codes and the entry record. No dependencies.
`default_nettype none
package lfu_pkg;
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_FREE,
        ST_VICTIM,
        ST_WRITE,
        ST_RESULT
    } state_t;

    localparam logic [0:0] CMD_GET = 1'b0;
    localparam logic [0:0] CMD_PUT = 1'b1;

    localparam logic [0:0] REG_CAPACITY = 1'b0;
    localparam logic [0:0] REG_TTL      = 1'b1;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CNT_W = 32;
    localparam int TIME_W = 32;
    localparam int CAP_W = 5;
    localparam int TTL_W = 31;
    localparam int CFG_W = 31;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [CNT_W-1:0]  count;
        logic [TIME_W-1:0] last_use;
    } entry_t;
endpackage
`default_nettype wire

@@ rtl/lfu_cmp.sv @@
// Shared compare unit of the LFU cache: expiry check, key match and
// victim ordering for one entry per cycle. Depends on lfu_pkg.
`default_nettype none
module lfu_cmp (
    input  wire lfu_pkg::entry_t          ent,
    input  wire logic [lfu_pkg::TIME_W-1:0] now,
    input  wire logic [lfu_pkg::TTL_W-1:0]  ttl,
    input  wire logic [lfu_pkg::KEY_W-1:0]  key,
    input  wire logic [lfu_pkg::CNT_W-1:0]  best_cnt,
    input  wire logic [lfu_pkg::TIME_W-1:0] best_age,
    output logic                            expired,
    output logic                            key_eq,
    output logic                            better,
    output logic [lfu_pkg::TIME_W-1:0]      age
);
    always_comb
    begin
        age     = now - ent.last_use;
        expired = age > {1'b0, ttl};
        key_eq  = ent.key == key;
        better  = (ent.count < best_cnt) ||
                  ((ent.count == best_cnt) && (age > best_age));
    end
endmodule
`default_nettype wire

@@ rtl/lfu_cache_with_ttl.sv @@
// Top level of the LFU cache with expiry: sequencer, entry memory and
// valid bits. Depends on lfu_pkg and lfu_cmp.
//
//  channel | signals                         | direction
//  in      | in_valid/in_ready cmd key value | into block
//  out     | out_valid/out_ready hit read_value | out of block
//  cfg     | cfg_we cfg_index cfg_data       | into block
//
// Each pass reads one entry a cycle once the first memory read has landed.
// From acceptance, a get miss passes SCAN, DECIDE and RESULT, a get hit
// SCAN, DECIDE, WRITE and RESULT. A put is back in idle after WRITE, reached
// from DECIDE (hit), via FREE (free slot) or via a VICTIM pass (eviction).
// Reset clears the valid bits, op time and control; no clearing pass.
// A get result waits in the output register; the next item is taken
// once it is delivered.
`default_nettype none
module lfu_cache_with_ttl #(
    parameter int ENTRIES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        cmd,
    input  wire logic [31:0] key,
    input  wire logic [31:0] value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             hit,
    output logic [31:0]      read_value,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [30:0] cfg_data
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    lfu_pkg::state_t state_reg, state_next;
    lfu_pkg::entry_t mem [ENTRIES];
    lfu_pkg::entry_t rd_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [IW-1:0] idx_reg, idx_next;
    logic          rd_ok_reg;
    logic [IW-1:0] slot_reg, slot_next;
    logic          found_reg, found_next, have_reg, have_next;
    logic [CW-1:0] used_reg, used_next;
    logic [31:0]   best_cnt_reg, best_cnt_next, best_age_reg, best_age_next;
    logic [31:0]   time_reg;
    logic [4:0]    cap_reg;
    logic [30:0]   ttl_reg;
    logic          cmd_reg;
    logic [31:0]   key_reg, val_reg;
    logic          out_valid_reg, hit_reg;
    logic [31:0]   rv_reg;
    logic [CW-1:0] cap_eff;
    logic expired, key_eq, better;
    logic [31:0] age;
    logic last;
    logic cur_valid;

    lfu_cmp u_cmp (
        .ent(rd_reg), .now(time_reg), .ttl(ttl_reg), .key(key_reg),
        .best_cnt(best_cnt_reg), .best_age(best_age_reg),
        .expired(expired), .key_eq(key_eq), .better(better), .age(age)
    );

    always_comb
    begin
        if (cap_reg == 5'd0)
            cap_eff = CW'(1);
        else if ({27'd0, cap_reg} > 32'(ENTRIES))
            cap_eff = CW'(ENTRIES);
        else
            cap_eff = CW'(cap_reg);
    end

    assign last      = idx_reg == IW'(ENTRIES - 1);
    assign cur_valid = valid_reg[idx_reg];
    assign in_ready  = (state_reg == lfu_pkg::ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign hit        = hit_reg;
    assign read_value = rv_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lfu_pkg::ST_IDLE:
                if (in_valid && in_ready)
                    state_next = lfu_pkg::ST_SCAN;
            lfu_pkg::ST_SCAN:
                if (rd_ok_reg && last)
                    state_next = lfu_pkg::ST_DECIDE;
            lfu_pkg::ST_DECIDE:
                if (found_reg)
                    state_next = lfu_pkg::ST_WRITE;
                else if (cmd_reg == lfu_pkg::CMD_GET)
                    state_next = lfu_pkg::ST_RESULT;
                else if (used_reg < cap_eff)
                    state_next = lfu_pkg::ST_FREE;
                else
                    state_next = lfu_pkg::ST_VICTIM;
            lfu_pkg::ST_FREE:
                state_next = lfu_pkg::ST_WRITE;
            lfu_pkg::ST_VICTIM:
                if (rd_ok_reg && last)
                    state_next = lfu_pkg::ST_WRITE;
            lfu_pkg::ST_WRITE:
                state_next = (cmd_reg == lfu_pkg::CMD_GET) ? lfu_pkg::ST_RESULT
                                                           : lfu_pkg::ST_IDLE;
            lfu_pkg::ST_RESULT:
                state_next = lfu_pkg::ST_IDLE;
            default:
                state_next = lfu_pkg::ST_IDLE;
        endcase
    end

    // datapath control
    always_comb
    begin
        idx_next      = idx_reg;
        slot_next     = slot_reg;
        found_next    = found_reg;
        have_next     = have_reg;
        used_next     = used_reg;
        best_cnt_next = best_cnt_reg;
        best_age_next = best_age_reg;
        case (state_reg)
            lfu_pkg::ST_IDLE:
            begin
                idx_next   = '0;
                found_next = 1'b0;
                have_next  = 1'b0;
                used_next  = '0;
            end
            lfu_pkg::ST_SCAN:
                if (rd_ok_reg)
                begin
                    if (cur_valid && !expired)
                    begin
                        used_next = used_reg + CW'(1);
                        if (!found_reg && key_eq)
                        begin
                            found_next = 1'b1;
                            slot_next  = idx_reg;
                        end
                    end
                    if (!last)
                        idx_next = idx_reg + IW'(1);
                end
            lfu_pkg::ST_DECIDE:
                // a hit rereads its own entry for the update
                idx_next = found_reg ? slot_reg : '0;
            lfu_pkg::ST_FREE:
            begin
                // lowest invalid slot; a priority pick over valid bits
                for (int i = ENTRIES - 1; i >= 0; i--)
                    if (!valid_reg[i])
                        slot_next = IW'(i);
            end
            lfu_pkg::ST_VICTIM:
                if (rd_ok_reg)
                begin
                    if (cur_valid && (!have_reg || better))
                    begin
                        have_next     = 1'b1;
                        slot_next     = idx_reg;
                        best_cnt_next = rd_reg.count;
                        best_age_next = age;
                    end
                    if (!last)
                        idx_next = idx_reg + IW'(1);
                end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= mem[idx_next];
        if (state_reg == lfu_pkg::ST_WRITE)
        begin
            if (found_reg)
            begin
                mem[slot_reg].value <= (cmd_reg == lfu_pkg::CMD_PUT) ? val_reg
                                                                     : rd_reg.value;
                mem[slot_reg].count <= (rd_reg.count == '1) ? rd_reg.count
                                                            : rd_reg.count + 32'd1;
                mem[slot_reg].last_use <= time_reg;
                mem[slot_reg].key <= rd_reg.key;
            end
            else
                mem[slot_reg] <= '{key: key_reg, value: val_reg, count: '0,
                                   last_use: time_reg};
        end
        if (state_reg == lfu_pkg::ST_IDLE && in_valid && in_ready)
        begin
            cmd_reg <= cmd;
            key_reg <= key;
            val_reg <= value;
        end
        idx_reg       <= idx_next;
        slot_reg      <= slot_next;
        best_cnt_reg  <= best_cnt_next;
        best_age_reg  <= best_age_next;
        used_reg      <= used_next;
        if (state_reg == lfu_pkg::ST_WRITE && cmd_reg == lfu_pkg::CMD_GET)
            rv_reg <= rd_reg.value;
        else if (state_reg == lfu_pkg::ST_RESULT && !found_reg)
            rv_reg <= '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfu_pkg::ST_IDLE;
            valid_reg     <= '0;
            time_reg      <= '0;
            cap_reg       <= 5'd16;
            ttl_reg       <= 31'h7FFF_FFFF;
            found_reg     <= 1'b0;
            have_reg      <= 1'b0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            found_reg <= found_next;
            have_reg  <= have_next;
            // read data lands in the cycle after the index settles
            rd_ok_reg <= (state_reg == state_next) &&
                         (state_reg == lfu_pkg::ST_SCAN || state_reg == lfu_pkg::ST_VICTIM)
                         ? !rd_ok_reg || last ? 1'b1 : 1'b1
                         : (state_next == lfu_pkg::ST_SCAN || state_next == lfu_pkg::ST_VICTIM)
                           ? 1'b0 : rd_ok_reg;
            if (cfg_we)
            begin
                if (cfg_index == lfu_pkg::REG_CAPACITY)
                    cap_reg <= cfg_data[4:0];
                else
                    ttl_reg <= cfg_data;
            end
            if (state_reg == lfu_pkg::ST_SCAN && rd_ok_reg && cur_valid && expired)
                valid_reg[idx_reg] <= 1'b0;
            if (state_reg == lfu_pkg::ST_WRITE)
            begin
                valid_reg[slot_reg] <= 1'b1;
                if (cmd_reg == lfu_pkg::CMD_PUT)
                    time_reg <= time_reg + 32'd1;
            end
            if (state_reg == lfu_pkg::ST_RESULT)
            begin
                out_valid_reg <= 1'b1;
                hit_reg       <= found_reg;
                time_reg      <= time_reg + 32'd1;
            end
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == lfu_pkg::ST_IDLE)
        else $error("ready outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_value))
        else $error("result dropped");
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> read_value == 32'd0)
        else $error("miss value not zero");
endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for lfu_cache_with_ttl: directed table plus random
// get/put traffic, predicted by an in-bench LFU cache model with expiry.
// Depends on lfu_pkg and the RTL top level.
`default_nettype none
module testbench;
    localparam int NUM_ENTRIES = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic        cmd;
        logic [31:0] key;
        logic [31:0] value;
        bit          fixed;     // expected result typed in
        logic        exp_hit;
        logic [31:0] exp_val;
    } stim_row_t;

    typedef struct {
        logic        hit;
        logic [31:0] rdata;
    } lookup_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        cmd;
    logic [31:0] key;
    logic [31:0] value;
    logic        out_valid;
    logic        out_ready;
    logic        hit;
    logic [31:0] read_value;
    logic        cfg_we;
    logic        cfg_index;
    logic [30:0] cfg_data;

    // predictor state
    bit          c_valid [NUM_ENTRIES];
    logic [31:0] c_key   [NUM_ENTRIES];
    logic [31:0] c_val   [NUM_ENTRIES];
    logic [31:0] c_count [NUM_ENTRIES];
    logic [31:0] c_last  [NUM_ENTRIES];
    logic [31:0] c_time;
    logic [4:0]  cfg_capacity;
    logic [30:0] cfg_ttl;

    lookup_t     pending_lookups[$];
    int          mismatches;
    int          idle_cycles;
    bit          no_idle;
    bit          done_driving;

    lfu_cache_with_ttl uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .key(key), .value(value),
        .out_valid(out_valid), .out_ready(out_ready),
        .hit(hit), .read_value(read_value),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic void cache_reset();
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            c_valid[i] = 1'b0;
        end
        c_time = '0;
        cfg_capacity = 5'd16;
        cfg_ttl = 31'h7FFF_FFFF;
    endfunction

    function automatic void cache_op(input logic op, input logic [31:0] k,
                                     input logic [31:0] v);
        int eff_cap;
        int found;
        int used;
        int slot;
        logic [31:0] best_cnt;
        logic [31:0] best_age;
        logic [31:0] age;
        lookup_t res;
        eff_cap = (cfg_capacity == 0) ? 1 :
                  (cfg_capacity > NUM_ENTRIES) ? NUM_ENTRIES : int'(cfg_capacity);
        found = -1;
        used = 0;
        slot = -1;
        best_cnt = '0;
        best_age = '0;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            if (c_valid[i] && (c_time - c_last[i]) > {1'b0, cfg_ttl})
                c_valid[i] = 1'b0;
        end
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            if (c_valid[i])
            begin
                used++;
                if (found < 0 && c_key[i] == k)
                    found = i;
            end
        end
        if (found >= 0)
        begin
            if (op == lfu_pkg::CMD_PUT)
                c_val[found] = v;
            if (c_count[found] != 32'hFFFF_FFFF)
                c_count[found]++;
            c_last[found] = c_time;
        end
        if (op == lfu_pkg::CMD_GET)
        begin
            res.hit = (found >= 0);
            res.rdata = (found >= 0) ? c_val[found] : '0;
            pending_lookups = {pending_lookups, res};
        end
        else if (found < 0)
        begin
            if (used < eff_cap)
            begin
                for (int i = 0; i < NUM_ENTRIES; i++)
                begin
                    if (!c_valid[i] && slot < 0)
                        slot = i;
                end
            end
            if (slot < 0)
            begin
                for (int i = 0; i < NUM_ENTRIES; i++)
                begin
                    if (c_valid[i])
                    begin
                        age = c_time - c_last[i];
                        if (slot < 0 || c_count[i] < best_cnt ||
                            (c_count[i] == best_cnt && age > best_age))
                        begin
                            slot = i;
                            best_cnt = c_count[i];
                            best_age = age;
                        end
                    end
                end
            end
            if (slot >= 0)
            begin
                c_valid[slot] = 1'b1;
                c_key[slot] = k;
                c_val[slot] = v;
                c_count[slot] = '0;
                c_last[slot] = c_time;
            end
        end
        c_time = c_time + 32'd1;
    endfunction

    task automatic sender_gap();
        if (!no_idle)
        begin
            while ($urandom_range(99) < 35)
            begin
                @(negedge clk);
            end
        end
    endtask

    task automatic send_op(input logic op, input logic [31:0] k, input logic [31:0] v);
        sender_gap();
        cache_op(op, k, v);
        in_valid = 1'b1;
        cmd = op;
        key = k;
        value = v;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain();
        while (pending_lookups.size() != 0)
        begin
            @(negedge clk);
        end
        // a put miss can still be scanning after the last result
        repeat (2 * NUM_ENTRIES + 8) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [30:0] data);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == lfu_pkg::REG_CAPACITY)
            cfg_capacity = data[4:0];
        else
            cfg_ttl = data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // out side: random stalls, compare against oldest expectation
    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 35);
    end

    always @(posedge clk)
    begin
        lookup_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_lookups.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result hit=%0b val=%h", hit, read_value);
            end
            else
            begin
                want = pending_lookups.pop_front();
                if (hit !== want.hit || read_value !== want.rdata)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp hit=%0b val=%h got hit=%0b val=%h",
                                 want.hit, want.rdata, hit, read_value);
                end
            end
        end
    end

    // watchdog on cycles with no accepted item
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic random_phase(input int n, input int key_span);
        logic [31:0] k;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
                k = $urandom();
            else
                k = 32'h8000_0000 ^ $urandom_range(key_span);
            send_op(1'($urandom_range(1)), k, $urandom());
        end
    endtask

    initial
    begin
        stim_row_t rows[$];
        stim_row_t r;
        logic [31:0] hot;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = lfu_pkg::CMD_GET;
        key = '0;
        value = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = lfu_pkg::REG_CAPACITY;
        cfg_data = '0;
        mismatches = 0;
        idle_cycles = 0;
        no_idle = 1'b0;
        done_driving = 1'b0;
        cache_reset();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty miss, key/value extremes, update, lookups
        rows = '{
            '{lfu_pkg::CMD_GET, 32'h0000_0000, 32'h0, 1, 1'b0, 32'h0},
            '{lfu_pkg::CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1'b0, 32'h0},
            '{lfu_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1'b0, 32'h0},
            '{lfu_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0, 32'h0},
            '{lfu_pkg::CMD_PUT, 32'h0000_0000, 32'h0000_0000, 0, 1'b0, 32'h0},
            '{lfu_pkg::CMD_GET, 32'h8000_0000, 32'h1234_5678, 1, 1'b1, 32'h7FFF_FFFF},
            '{lfu_pkg::CMD_GET, 32'h7FFF_FFFF, 32'h0, 1, 1'b1, 32'h8000_0000},
            '{lfu_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0, 1, 1'b1, 32'hFFFF_FFFF},
            '{lfu_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'h5555_AAAA, 0, 1'b0, 32'h0},
            '{lfu_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0, 1, 1'b1, 32'h5555_AAAA},
            '{lfu_pkg::CMD_GET, 32'h0000_0001, 32'h0, 1, 1'b0, 32'h0},
            '{lfu_pkg::CMD_GET, 32'h0000_0000, 32'h0, 1, 1'b1, 32'h0}
        };
        foreach (rows[i])
        begin
            r = rows[i];
            send_op(r.cmd, r.key, r.value);
            if (r.fixed && pending_lookups.size() != 0)
            begin
                // typed-in value must agree with the predictor too
                if (pending_lookups[$].hit !== r.exp_hit ||
                    pending_lookups[$].rdata !== r.exp_val)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("table row %0d disagrees with predictor", i);
                end
            end
        end

        // capacity 1 with eviction, then capacity lowered under valid count
        write_reg(lfu_pkg::REG_CAPACITY, 31'd1);
        send_op(lfu_pkg::CMD_PUT, 32'h0000_1000, 32'hA);
        send_op(lfu_pkg::CMD_GET, 32'h0000_1000, 32'h0);
        send_op(lfu_pkg::CMD_GET, 32'h8000_0000, 32'h0);
        write_reg(lfu_pkg::REG_CAPACITY, 31'd0);
        send_op(lfu_pkg::CMD_PUT, 32'h0000_2000, 32'hB);
        send_op(lfu_pkg::CMD_GET, 32'h0000_2000, 32'h0);
        write_reg(lfu_pkg::REG_CAPACITY, 31'd31);
        // ttl zero: every entry, even one used in the previous op, expires
        write_reg(lfu_pkg::REG_TTL, 31'd0);
        send_op(lfu_pkg::CMD_PUT, 32'h0000_3000, 32'hC);
        send_op(lfu_pkg::CMD_GET, 32'h0000_3000, 32'h0);
        send_op(lfu_pkg::CMD_GET, 32'h0000_2000, 32'h0);

        // random phases over several settings; sender waits for empty pipe
        write_reg(lfu_pkg::REG_TTL, 31'd20);
        write_reg(lfu_pkg::REG_CAPACITY, 31'd4);
        random_phase(120, 12);
        write_reg(lfu_pkg::REG_CAPACITY, 31'd16);
        write_reg(lfu_pkg::REG_TTL, 31'h7FFF_FFFF);
        no_idle = 1'b1;
        random_phase(120, 24);
        no_idle = 1'b0;
        write_reg(lfu_pkg::REG_CAPACITY, 31'd2);
        random_phase(100, 6);
        write_reg(lfu_pkg::REG_TTL, 31'd5);
        write_reg(lfu_pkg::REG_CAPACITY, 31'd8);
        random_phase(120, 16);
        write_reg(lfu_pkg::REG_TTL, 31'd1);
        write_reg(lfu_pkg::REG_CAPACITY, 31'd3);
        random_phase(100, 5);
        write_reg(lfu_pkg::REG_TTL, 31'd40);
        write_reg(lfu_pkg::REG_CAPACITY, 31'd12);
        // put one key before a random phase and look it up after it
        hot = 32'h8000_0001;
        send_op(lfu_pkg::CMD_PUT, hot, 32'h1);
        random_phase(140, 30);
        send_op(lfu_pkg::CMD_GET, hot, 32'h0);

        drain();
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
rtl/lfu_pkg.sv
rtl/lfu_cmp.sv
rtl/lfu_cache_with_ttl.sv
verif/testbench.sv
